>>> sv/wcm_pkg.sv
// package: widths, defaults and cell control type for the walk counter
`timescale 1ns / 1ps
package wcm_pkg;

  localparam int COUNT_W             = 43;
  localparam int NODE_W              = 3;
  localparam int LEN_W               = 4;
  localparam int ADJ_W               = 64;
  localparam int ADJ_STRIDE          = 8;
  localparam int DEF_NODE_COUNT      = 8;
  localparam int DEF_MAX_WALK_LENGTH = 15;

  typedef struct packed {
    logic              load;
    logic              shift;
    logic              commit;
    logic              src_ok;
    logic [NODE_W-1:0] src;
  } cell_ctrl_t;

endpackage

>>> sv/wcm_in_if.sv
// interface: query channel (source, destination, length)
`timescale 1ns / 1ps
interface wcm_in_if;
  logic                        valid;
  logic                        ready;
  logic [wcm_pkg::NODE_W-1:0]  source_node;
  logic [wcm_pkg::NODE_W-1:0]  dest_node;
  logic [wcm_pkg::LEN_W-1:0]   walk_length;

  modport source (output valid, source_node, dest_node, walk_length, input ready);
  modport sink   (input valid, source_node, dest_node, walk_length, output ready);
endinterface

>>> sv/wcm_out_if.sv
// interface: result channel (walk count)
`timescale 1ns / 1ps
interface wcm_out_if;
  logic                        valid;
  logic                        ready;
  logic [wcm_pkg::COUNT_W-1:0] walk_count;

  modport source (output valid, walk_count, input ready);
  modport sink   (input valid, walk_count, output ready);
endinterface

>>> sv/wcm_cell.sv
// cell: one entry of the row vector, accumulates its column product as the ring rotates
`timescale 1ns / 1ps
module wcm_cell #(
  parameter int J = 0
) (
  input  logic                                  clk,
  input  wcm_pkg::cell_ctrl_t                   ctrl,
  input  logic [wcm_pkg::ADJ_STRIDE-1:0]        col,
  input  logic [wcm_pkg::COUNT_W-1:0]           row_in,
  input  logic [wcm_pkg::NODE_W-1:0]            idx_in,
  output logic [wcm_pkg::COUNT_W-1:0]           row_out,
  output logic [wcm_pkg::NODE_W-1:0]            idx_out
);
  import wcm_pkg::*;

  logic [COUNT_W-1:0] row_r;
  logic [COUNT_W-1:0] acc_r;
  logic [NODE_W-1:0]  idx_r;
  logic [COUNT_W-1:0] term;
  logic [COUNT_W-1:0] sum;

  assign term    = col[idx_r] ? row_r : '0;
  assign sum     = acc_r + term;
  assign row_out = row_r;
  assign idx_out = idx_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      row_r <= {{(COUNT_W-1){1'b0}}, ctrl.src_ok & col[ctrl.src]};
      idx_r <= NODE_W'(J);
      acc_r <= '0;
    end else if (ctrl.shift) begin
      row_r <= ctrl.commit ? sum : row_in;
      idx_r <= idx_in;
      acc_r <= ctrl.commit ? '0 : sum;
    end
  end

endmodule

>>> sv/walk_count_matrix_power_core.sv
// top level: walk counter built from a ring of accumulate cells
//   channel  | dir | handshake          | payload
//   in_ch    | in  | valid/ready        | source_node, dest_node, walk_length
//   out_ch   | out | valid/ready        | walk_count
//   cfg_*    | in  | cfg_we (no ready)  | cfg_wdata = adjacency matrix
// one vector-matrix round is one ring rotation, each cell adding one term per step
// the result is computed for L = length clamped to 1..MAX
// next query is accepted once the result sits in the output register
// a stalled result holds in the output register; a finished item waits until it drains
// reset is synchronous, active low, and clears the matrix and all control state
`timescale 1ns / 1ps
module walk_count_matrix_power_core #(
  parameter int NODE_COUNT      = wcm_pkg::DEF_NODE_COUNT,
  parameter int MAX_WALK_LENGTH = wcm_pkg::DEF_MAX_WALK_LENGTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  wcm_in_if.sink                    in_ch,
  wcm_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [wcm_pkg::ADJ_W-1:0] cfg_wdata
);
  import wcm_pkg::*;

  localparam int STEP_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  state_t             state_r;
  logic [ADJ_W-1:0]   adj_r;
  logic [STEP_W-1:0]  step_r;
  logic [LEN_W-1:0]   rounds_r;
  logic [NODE_W-1:0]  dst_r;
  logic               src_ok_r;
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;

  cell_ctrl_t         ctrl;
  logic               in_acc;
  logic               last_step;
  logic               out_load;
  logic [LEN_W-1:0]   len_eff;
  logic [COUNT_W-1:0] sel_count;

  logic [COUNT_W-1:0] rows [NODE_COUNT];
  logic [NODE_W-1:0]  idxs [NODE_COUNT];

  assign in_ch.ready       = (state_r == S_IDLE);
  assign in_acc            = in_ch.valid & in_ch.ready;
  assign last_step         = (step_r == STEP_W'(NODE_COUNT - 1));
  assign out_load          = (state_r == S_DONE) & (!out_valid_r | out_ch.ready);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.walk_count = out_count_r;

  always_comb begin
    len_eff = in_ch.walk_length;
    if (len_eff == '0) len_eff = LEN_W'(1);
    if (len_eff > LEN_W'(MAX_WALK_LENGTH)) len_eff = LEN_W'(MAX_WALK_LENGTH);
  end

  always_comb begin
    ctrl.load   = in_acc;
    ctrl.shift  = (state_r == S_RUN);
    ctrl.commit = (state_r == S_RUN) & last_step;
    ctrl.src    = in_ch.source_node;
    ctrl.src_ok = ({1'b0, in_ch.source_node} < (NODE_W+1)'(NODE_COUNT));
  end

  for (genvar j = 0; j < NODE_COUNT; j++) begin : g_cell
    logic [ADJ_STRIDE-1:0] col;
    for (genvar k = 0; k < ADJ_STRIDE; k++) begin : g_col
      assign col[k] = adj_r[k*ADJ_STRIDE + j];
    end
    wcm_cell #(.J(j)) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .col     (col),
      .row_in  (rows[(j+1) % NODE_COUNT]),
      .idx_in  (idxs[(j+1) % NODE_COUNT]),
      .row_out (rows[j]),
      .idx_out (idxs[j])
    );
  end

  always_comb begin
    sel_count = '0;
    for (int j = 0; j < NODE_COUNT; j++) begin
      if (dst_r == NODE_W'(j)) sel_count = rows[j];
    end
    if (!src_ok_r) sel_count = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adj_r <= '0;
    end else if (cfg_we) begin
      adj_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      rounds_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            dst_r    <= in_ch.dest_node;
            src_ok_r <= ctrl.src_ok;
            rounds_r <= len_eff - LEN_W'(1);
            step_r   <= '0;
            state_r  <= (len_eff == LEN_W'(1)) ? S_DONE : S_RUN;
          end
        end
        S_RUN: begin
          if (last_step) begin
            step_r   <= '0;
            rounds_r <= rounds_r - LEN_W'(1);
            if (rounds_r == LEN_W'(1)) state_r <= S_DONE;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_count_r <= sel_count;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/wcm_checker.sv
// checker: port-level properties of the walk counter, bound to the top level
`timescale 1ns / 1ps
module wcm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [wcm_pkg::COUNT_W-1:0] walk_count
);
  import wcm_pkg::*;

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(64'h400_0000_0000);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(walk_count))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous one in flight");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after accept");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> walk_count <= MAX_COUNT)
    else $error("walk count out of range");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind walk_count_matrix_power_core wcm_checker u_wcm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .walk_count (out_ch.walk_count)
);

>>> tb/walk_count_checker.sv
// checker: predicts the walk count of each query and compares it with the result channel
`timescale 1ns / 1ps
module walk_count_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  wcm_in_if                         in_ch,
  wcm_out_if                        out_ch,
  input  logic                      cfg_we,
  input  logic [wcm_pkg::ADJ_W-1:0] cfg_wdata,
  output int unsigned               error_count,
  output int unsigned               waiting
);
  import wcm_pkg::*;

  localparam int NODES   = DEF_NODE_COUNT;
  localparam int MAX_LEN = DEF_MAX_WALK_LENGTH;

  logic [ADJ_W-1:0]   adjacency;
  logic [COUNT_W-1:0] expected_counts[$];

  function automatic bit has_edge(input logic [ADJ_W-1:0] adj, input int from_node,
                                  input int to_node);
    if (from_node >= NODES || to_node >= NODES) return 1'b0;
    return adj[from_node * ADJ_STRIDE + to_node];
  endfunction

  function automatic logic [COUNT_W-1:0] count_walks(input logic [ADJ_W-1:0] adj,
                                                     input logic [NODE_W-1:0] from_node,
                                                     input logic [NODE_W-1:0] to_node,
                                                     input logic [LEN_W-1:0] len);
    logic [COUNT_W-1:0] row [ADJ_STRIDE];
    logic [COUNT_W-1:0] nxt [ADJ_STRIDE];
    logic [COUNT_W-1:0] acc;
    int rounds;
    rounds = (len == 0) ? 1 : int'(len);
    if (rounds > MAX_LEN) rounds = MAX_LEN;
    for (int j = 0; j < ADJ_STRIDE; j++) begin
      row[j] = has_edge(adj, int'(from_node), j) ? COUNT_W'(1) : '0;
    end
    for (int r = 1; r < rounds; r++) begin
      for (int j = 0; j < ADJ_STRIDE; j++) begin
        acc = '0;
        for (int k = 0; k < ADJ_STRIDE; k++) begin
          if (has_edge(adj, k, j)) acc = acc + row[k];
        end
        nxt[j] = acc;
      end
      row = nxt;
    end
    if (int'(from_node) >= NODES || int'(to_node) >= NODES) return '0;
    return row[to_node];
  endfunction

  task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] want,
                                 input logic [COUNT_W-1:0] got);
    error_count++;
    if (error_count <= 10) begin
      $display("mismatch at %0t: %s, expected walk_count %0d, got %0d",
               $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    logic [COUNT_W-1:0] want;
    if (!rst_n) begin
      adjacency = '0;
      expected_counts.delete();
      waiting <= 0;
    end else begin
      if (cfg_we) adjacency = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        expected_counts.push_back(count_walks(adjacency, in_ch.source_node,
                                              in_ch.dest_node, in_ch.walk_length));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_counts.size() == 0) begin
          report_mismatch("result with no query waiting", '0, out_ch.walk_count);
        end else begin
          want = expected_counts.pop_front();
          if (out_ch.walk_count !== want) begin
            report_mismatch("wrong walk_count", want, out_ch.walk_count);
          end
        end
      end
      waiting <= expected_counts.size();
    end
  end

endmodule

>>> tb/testbench.sv
// testbench top: clock, reset, query and matrix stimulus, result back-pressure, verdict
`timescale 1ns / 1ps
module testbench;
  import wcm_pkg::*;

  localparam int PHASES            = 12;
  localparam int QUERIES_PER_PHASE = 108;
  localparam int HOLD_CYCLES       = 400;
  localparam int DRAIN_CYCLES      = (DEF_MAX_WALK_LENGTH - 1) * DEF_NODE_COUNT + 16;
  localparam int LIMIT             = 1_500_000;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [ADJ_W-1:0] cfg_wdata;
  int unsigned      src_idle_pct;
  int unsigned      sink_idle_pct;
  int unsigned      error_count;
  int unsigned      waiting;
  int unsigned      cycles;
  bit               hold_off_req;

  wcm_in_if  in_ch();
  wcm_out_if out_ch();

  walk_count_matrix_power_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  walk_count_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .error_count (error_count),
    .waiting     (waiting)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin
    bit held;
    out_ch.ready = 1'b0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic send_query(input logic [NODE_W-1:0] from_node,
                            input logic [NODE_W-1:0] to_node,
                            input logic [LEN_W-1:0] len);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.source_node <= from_node;
    in_ch.dest_node   <= to_node;
    in_ch.walk_length <= len;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
  endtask

  task automatic load_adjacency(input logic [ADJ_W-1:0] adj);
    cfg_we    <= 1'b1;
    cfg_wdata <= adj;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [ADJ_W-1:0] ring;
    logic [ADJ_W-1:0] adj;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.source_node = '0;
    in_ch.dest_node   = '0;
    in_ch.walk_length = '0;
    src_idle_pct      = 38;
    sink_idle_pct     = 63;
    hold_off_req      = 1'b0;
    ring              = '0;
    for (int i = 0; i < DEF_NODE_COUNT; i++) begin
      ring[i * ADJ_STRIDE + (i + 1) % DEF_NODE_COUNT] = 1'b1;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // complete graph with self loops: largest counts
    load_adjacency('1);
    send_query(3'd0, 3'd7, 4'd15);
    send_query(3'd7, 3'd0, 4'd15);
    send_query(3'd3, 3'd5, 4'd1);
    send_query(3'd3, 3'd5, 4'd0);
    send_query(3'd0, 3'd0, 4'd2);
    settle();
    // self loops only
    load_adjacency(64'h8040201008040201);
    send_query(3'd4, 3'd4, 4'd15);
    send_query(3'd4, 3'd5, 4'd15);
    send_query(3'd7, 3'd7, 4'd0);
    settle();
    // directed ring
    load_adjacency(ring);
    send_query(3'd0, 3'd7, 4'd7);
    send_query(3'd0, 3'd0, 4'd8);
    send_query(3'd2, 3'd2, 4'd0);
    send_query(3'd0, 3'd1, 4'd1);
    settle();
    // no edges
    load_adjacency('0);
    send_query(3'd7, 3'd7, 4'd15);
    send_query(3'd0, 3'd0, 4'd0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == 0) begin
        adj = '1;
      end else if (p == PHASES - 1) begin
        adj = '0;
      end else begin
        case ($urandom_range(2))
          0: adj = {$urandom, $urandom};
          1: adj = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
          default: adj = {$urandom, $urandom} | {$urandom, $urandom};
        endcase
      end
      load_adjacency(adj);
      src_idle_pct  = (p < 4) ? 38 : (p < 8) ? 63 : 0;
      sink_idle_pct = (p < 4) ? 63 : (p < 8) ? 38 : 0;
      if (p == 8) hold_off_req = 1'b1;
      repeat (QUERIES_PER_PHASE) begin
        send_query(NODE_W'($urandom_range(7)), NODE_W'($urandom_range(7)),
                   LEN_W'($urandom_range(15)));
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/wcm_pkg.sv
sv/wcm_in_if.sv
sv/wcm_out_if.sv
sv/wcm_cell.sv
sv/walk_count_matrix_power_core.sv
sv/wcm_checker.sv
tb/walk_count_checker.sv
tb/testbench.sv
